// File: design/gcc_pkg.sv
// Shared widths and sizes for the greedy coin change core.
package gcc_pkg;

  localparam int unsigned DENOM_W   = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned SLOTS     = 8;
  localparam int unsigned SLOT_IDX_W = 3;
  localparam int unsigned OUT_DATA_W = 136;

  typedef logic [DENOM_W-1:0] denom_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef count_t [SLOTS-1:0] count_vec_t;

endpackage

// File: design/gcc_cell.sv
// One restoring-division bit cell: trial subtract of a shifted denomination.
module gcc_cell #(
  parameter int unsigned AMOUNT_BITS = 16,
  parameter int unsigned SLOT        = 0,
  parameter int unsigned SHIFT       = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ld,
  input  logic                     valid_i,
  input  logic [AMOUNT_BITS-1:0]   rem_i,
  input  logic [AMOUNT_BITS-1:0]   quo_i,
  input  gcc_pkg::count_vec_t      cnt_i,
  input  gcc_pkg::denom_t          denom,
  output logic                     valid_o,
  output logic [AMOUNT_BITS-1:0]   rem_o,
  output logic [AMOUNT_BITS-1:0]   quo_o,
  output gcc_pkg::count_vec_t      cnt_o
);

  localparam int unsigned WIDE_W = AMOUNT_BITS + gcc_pkg::DENOM_W;
  localparam bit FIRST = (SHIFT == AMOUNT_BITS - 1);

  logic                   valid_r;
  logic [AMOUNT_BITS-1:0] rem_r, rem_nxt;
  logic [AMOUNT_BITS-1:0] quo_r, quo_nxt;
  gcc_pkg::count_vec_t    cnt_r, cnt_nxt;
  logic [WIDE_W-1:0]      trial;
  logic [WIDE_W-1:0]      rem_ext;
  logic [WIDE_W-1:0]      quo_ext;
  logic                   take;
  logic                   sat;

  always_comb begin
    trial   = {{AMOUNT_BITS{1'b0}}, denom} << SHIFT;
    rem_ext = {{gcc_pkg::DENOM_W{1'b0}}, rem_i};
    take    = (denom != '0) && (rem_ext >= trial);
    rem_nxt = take ? (rem_i - trial[AMOUNT_BITS-1:0]) : rem_i;
    // start a fresh quotient at the top bit of each slot
    quo_nxt = FIRST ? '0 : quo_i;
    quo_nxt[SHIFT] = take;
    quo_ext = {{gcc_pkg::DENOM_W{1'b0}}, quo_nxt};
    sat     = |quo_ext[WIDE_W-1:gcc_pkg::COUNT_W];
    cnt_nxt = cnt_i;
    if (SHIFT == 0) begin
      cnt_nxt[SLOT] = sat ? {gcc_pkg::COUNT_W{1'b1}} : quo_ext[gcc_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;
  assign cnt_o   = cnt_r;

endmodule

// File: design/greedy_coin_change_core.sv
// Greedy coin change core: a chain of division bit cells per denomination slot.
// One cell per quotient bit, and the output register follows the last cell.
// Throughput: one amount per cycle; the whole chain advances together, held only
// when the output register is full and not taken; an empty first cell still loads.
// Reset clears all denominations to zero and drops every request in flight.
module greedy_coin_change_core #(
  parameter int unsigned NUM_DENOMS  = 8,
  parameter int unsigned AMOUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((AMOUNT_BITS+7)/8)*8-1:0]      in_tdata,   // [AMOUNT_BITS-1:0] amount
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // count_0 .. count_7 (16 bits each), solved, zero fill
  output logic [gcc_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gcc_pkg::SLOT_IDX_W-1:0]        cfg_index,
  input  logic [gcc_pkg::DENOM_W-1:0]           cfg_data
);

  localparam int unsigned NST = NUM_DENOMS * AMOUNT_BITS;
  localparam int unsigned PAD_W =
    gcc_pkg::OUT_DATA_W - gcc_pkg::SLOTS * gcc_pkg::COUNT_W - 1;

  gcc_pkg::denom_t [gcc_pkg::SLOTS-1:0] denom_r;

  logic                   st_valid [0:NST];
  logic [AMOUNT_BITS-1:0] st_rem   [0:NST];
  logic [AMOUNT_BITS-1:0] st_quo   [0:NST];
  gcc_pkg::count_vec_t    st_cnt   [0:NST];

  logic                   adv;
  logic                   ld_first;
  logic                   solved;

  logic                   out_valid_r;
  gcc_pkg::count_vec_t    out_cnt_r;
  logic                   out_solved_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      denom_r <= '0;
    end else if (cfg_valid) begin
      denom_r[cfg_index] <= cfg_data;
    end
  end

  // advance the chain unless a finished result is stuck in the output register
  assign adv      = !out_valid_r || out_tready;
  assign ld_first = adv || !st_valid[1];
  assign in_tready = ld_first;

  assign st_valid[0] = in_tvalid;
  assign st_rem[0]   = in_tdata[AMOUNT_BITS-1:0];
  assign st_quo[0]   = '0;
  assign st_cnt[0]   = '0;

  for (genvar s = 0; s < NUM_DENOMS; s++) begin : g_slot
    for (genvar b = 0; b < AMOUNT_BITS; b++) begin : g_bit
      localparam int unsigned IDX = s * AMOUNT_BITS + b;
      gcc_cell #(
        .AMOUNT_BITS (AMOUNT_BITS),
        .SLOT        (s),
        .SHIFT       (AMOUNT_BITS - 1 - b)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld      ((IDX == 0) ? ld_first : adv),
        .valid_i (st_valid[IDX]),
        .rem_i   (st_rem[IDX]),
        .quo_i   (st_quo[IDX]),
        .cnt_i   (st_cnt[IDX]),
        .denom   (denom_r[s]),
        .valid_o (st_valid[IDX+1]),
        .rem_o   (st_rem[IDX+1]),
        .quo_o   (st_quo[IDX+1]),
        .cnt_o   (st_cnt[IDX+1])
      );
    end
  end

  assign solved = (st_rem[NST] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_valid[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_valid[NST]) begin
      // drop all counts when change is not exact
      out_cnt_r    <= solved ? st_cnt[NST] : '0;
      out_solved_r <= solved;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_solved_r, out_cnt_r};

endmodule

// File: tb/tb.sv
// Self-checking testbench for the greedy coin change core.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_DENOMS   = 8;
  localparam int unsigned AMOUNT_BITS  = 16;
  localparam int unsigned AMOUNT_W     = ((AMOUNT_BITS + 7) / 8) * 8;
  localparam longint unsigned TIMEOUT_NS = 64'd20_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_PHASES = 15;
  localparam int unsigned PRESSURE_PHASE = 6;

  typedef gcc_pkg::denom_t [gcc_pkg::SLOTS-1:0] denom_set_t;

  typedef struct packed {
    logic [AMOUNT_BITS-1:0] amount;
    logic                   solved;
    gcc_pkg::count_vec_t    counts;
  } change_t;

  class change_scoreboard;
    denom_set_t  denoms;
    change_t     expected_q[$];
    int unsigned errors;

    function new();
      denoms = '0;
      errors = 0;
    endfunction

    function void set_denom(int unsigned idx, gcc_pkg::denom_t val);
      denoms[idx] = val;
    endfunction

    function change_t greedy_split(logic [AMOUNT_BITS-1:0] amount);
      change_t                res;
      logic [AMOUNT_BITS-1:0] rem;
      logic [AMOUNT_BITS-1:0] quo;
      res.amount = amount;
      res.counts = '0;
      rem = amount;
      for (int i = 0; i < gcc_pkg::SLOTS; i++) begin
        if (i < NUM_DENOMS && denoms[i] != '0) begin
          quo = rem / denoms[i];
          rem = rem % denoms[i];
          res.counts[i] = (quo > {gcc_pkg::COUNT_W{1'b1}}) ? '1 : gcc_pkg::count_t'(quo);
        end
      end
      res.solved = (rem == '0);
      // no exact change: every count reads zero
      if (!res.solved) res.counts = '0;
      return res;
    endfunction

    function void note_amount(logic [AMOUNT_BITS-1:0] amount);
      expected_q.push_back(greedy_split(amount));
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(logic [gcc_pkg::OUT_DATA_W-1:0] data);
      change_t             want;
      gcc_pkg::count_vec_t got_counts;
      logic                got_solved;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      want = expected_q.pop_front();
      got_counts = data[gcc_pkg::SLOTS*gcc_pkg::COUNT_W-1:0];
      got_solved = data[gcc_pkg::SLOTS*gcc_pkg::COUNT_W];
      for (int i = 0; i < gcc_pkg::SLOTS; i++) begin
        if (got_counts[i] !== want.counts[i])
          report_mismatch($sformatf("amount %0d: count_%0d got %0d, expected %0d",
                                    want.amount, i, got_counts[i], want.counts[i]));
      end
      if (got_solved !== want.solved)
        report_mismatch($sformatf("amount %0d: solved got %b, expected %b",
                                  want.amount, got_solved, want.solved));
    endtask
  endclass

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [AMOUNT_W-1:0]              in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [gcc_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [gcc_pkg::SLOT_IDX_W-1:0]   cfg_index  = '0;
  logic [gcc_pkg::DENOM_W-1:0]      cfg_data   = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_hold_cycles = 0;

  change_scoreboard sb = new();

  greedy_coin_change_core #(
    .NUM_DENOMS (NUM_DENOMS),
    .AMOUNT_BITS(AMOUNT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_tready = 1'b0;
      rx_hold_cycles--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task wait_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task send_amount(input logic [AMOUNT_BITS-1:0] amount);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = AMOUNT_W'(amount);
    do @(posedge clk); while (!in_tready);
    sb.note_amount(amount);
  endtask

  // write all slots while nothing is in flight
  task load_denoms(input denom_set_t d);
    wait_drain();
    for (int i = 0; i < gcc_pkg::SLOTS; i++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = i[gcc_pkg::SLOT_IDX_W-1:0];
      cfg_data  = d[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_denom(i, d[i]);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task make_denoms(output denom_set_t d, input int unsigned style);
    d = '0;
    case (style)
      0, 1: begin
        // strictly descending chain; style 0 always ends in a unit coin
        d[0] = gcc_pkg::denom_t'($urandom_range(65535, 8));
        for (int i = 1; i < gcc_pkg::SLOTS; i++) begin
          if (d[i-1] > 2)
            d[i] = gcc_pkg::denom_t'($urandom_range(d[i-1] - 1, (style == 0) ? 1 : 2));
          else if (d[i-1] == 2 && style == 0) d[i] = 16'd1;
        end
        if (style == 0 && d[gcc_pkg::SLOTS-1] != 0) d[gcc_pkg::SLOTS-1] = 16'd1;
      end
      2: begin
        // unordered, with duplicates and holes
        for (int i = 0; i < gcc_pkg::SLOTS; i++)
          d[i] = ($urandom_range(3) == 0) ? '0 : gcc_pkg::denom_t'($urandom_range(40, 1));
      end
      3: begin
        for (int i = 0; i < gcc_pkg::SLOTS; i++) d[i] = gcc_pkg::denom_t'($urandom());
      end
      default: begin
        for (int i = 0; i < $urandom_range(4, 1); i++)
          d[i] = gcc_pkg::denom_t'($urandom_range(12, 1));
      end
    endcase
  endtask

  function logic [AMOUNT_BITS-1:0] pick_amount(denom_set_t d);
    gcc_pkg::denom_t low;
    low = '0;
    for (int i = 0; i < gcc_pkg::SLOTS; i++)
      if (d[i] != '0 && (low == '0 || d[i] < low)) low = d[i];
    case ($urandom_range(3))
      0, 1:    return AMOUNT_BITS'($urandom());
      2:       return AMOUNT_BITS'($urandom_range(1000));
      default: return AMOUNT_BITS'(low * $urandom_range(60));
    endcase
  endfunction

  initial begin
    denom_set_t  dset;
    int unsigned n_items;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset state: no coins at all
    send_amount(16'd0);
    send_amount(16'd1);
    send_amount(16'hFFFF);

    // ordinary descending set, every coin used once for 388
    load_denoms({16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd200});
    send_amount(16'd0);
    send_amount(16'hFFFF);
    send_amount(16'd1);
    send_amount(16'd388);
    send_amount(16'hFFFE);

    // largest coin, hole, duplicate, out-of-order slot (listed from slot 7 down)
    load_denoms({16'd1, 16'd0, 16'd3, 16'd9, 16'd7, 16'd7, 16'd0, 16'hFFFF});
    send_amount(16'hFFFF);
    send_amount(16'hFFFE);
    send_amount(16'd20);

    // greedy misses: 4 and 3 only
    load_denoms({96'd0, 16'd3, 16'd4});
    send_amount(16'd0);
    send_amount(16'd5);
    send_amount(16'd6);
    send_amount(16'd7);

    // unit coin in the last slot only, count reaches full scale
    load_denoms({16'd1, 112'd0});
    send_amount(16'hFFFF);
    send_amount(16'h5555);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      make_denoms(dset, phase % 5);
      load_denoms(dset);
      n_items = 100;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (phase == PRESSURE_PHASE) begin
        // hold the output long enough to fill the chain and stall the input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_cycles = 600;
        n_items        = 300;
      end
      for (int k = 0; k < n_items; k++) send_amount(pick_amount(dset));
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] timeout, %0d results outstanding", $realtime, sb.expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
